// File: hw/rtl/utf8_stream_decoder_macros.svh
// Assertion macros used by the decoder front end.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define U8SD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define U8SD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define U8SD_ASSERT(lbl, prop, msg)
`define U8SD_NEVER(lbl, cond, msg)
`endif
`endif

// File: hw/rtl/utf8sd_pkg.sv
// Types, constants and helper functions for the UTF-8 stream decoder.
package utf8sd_pkg;

  localparam int unsigned PEND_DEPTH = 5;
  localparam int unsigned MAX_BYTES  = 6;
  localparam int unsigned CP_W       = 31;
  localparam int unsigned Q_DEPTH    = 2;

  localparam logic [1:0] KIND_CODE    = 2'd0;
  localparam logic [1:0] KIND_CTRL    = 2'd1;
  localparam logic [1:0] KIND_UNKNOWN = 2'd2;

  localparam logic [30:0] CP_BOM      = 31'h0000FEFF;
  localparam logic [30:0] CP_SURR_LO  = 31'h0000D800;
  localparam logic [30:0] CP_SURR_HI  = 31'h0000DFFF;

  // One unit of work for the result side: a single result, or a burst of raw bytes.
  typedef struct packed {
    logic                  multi;
    logic [1:0]            kind;
    logic [CP_W-1:0]       value;
    logic [5:0][7:0]       bytes;
    logic [2:0]            cnt;
  } job_t;

  function automatic logic [2:0] seq_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b >= 8'hFE)      len = 3'd0;
    else if (b >= 8'hFC) len = 3'd6;
    else if (b >= 8'hF8) len = 3'd5;
    else if (b >= 8'hF0) len = 3'd4;
    else if (b >= 8'hE0) len = 3'd3;
    else if (b >= 8'hC0) len = 3'd2;
    return len;
  endfunction

  function automatic logic [7:0] lead_mask(input logic [2:0] len);
    logic [7:0] m;
    case (len)
      3'd2:    m = 8'h1F;
      3'd3:    m = 8'h0F;
      3'd4:    m = 8'h07;
      3'd5:    m = 8'h03;
      3'd6:    m = 8'h01;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic [CP_W-1:0] min_value(input logic [2:0] len);
    logic [CP_W-1:0] v;
    case (len)
      3'd2:    v = 31'h00000080;
      3'd3:    v = 31'h00000800;
      3'd4:    v = 31'h00010000;
      3'd5:    v = 31'h00200000;
      3'd6:    v = 31'h04000000;
      default: v = 31'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/utf8_stream_decoder.sv
// UTF-8 (1 to 6 byte form) stream decoder, top level.
// Takes one byte word per cycle while in_full is low and gives one result word
// per cycle while out_pop is high. A byte that completes or rejects a sequence
// is decoded in the same cycle it is taken; its results then sit in a two-entry
// job queue. A rejected sequence or interruption yields one unknown-byte word
// per held byte plus the current one (up to six), a flush one per held byte;
// the result port drains these one per cycle while popped, so in_full rises
// only when such bursts or a stalled result port back up the queue. Results
// pass the job queue, then the output register. No clearing pass after reset.
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_flush,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_kind,
  output logic [30:0] out_value,
  output logic        out_last
);
  import utf8sd_pkg::*;

  job_t front_job;
  job_t head_job;
  logic front_push;
  logic q_full;
  logic head_valid;
  logic head_pop;

  assign in_full = q_full;

  utf8sd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_data_byte (in_data_byte),
    .in_flush     (in_flush),
    .q_full       (q_full),
    .job_push     (front_push),
    .job          (front_job)
  );

  utf8sd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (front_push),
    .wr_job     (front_job),
    .full       (q_full),
    .rd_en      (head_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  utf8sd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .head_pop   (head_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_kind   (out_kind),
    .out_value  (out_value),
    .out_last   (out_last)
  );

endmodule

// File: hw/rtl/utf8sd_front.sv
// Front end: accepts bytes, tracks open sequences and issues result jobs.
`include "utf8_stream_decoder_macros.svh"
module utf8sd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [7:0]        in_data_byte,
  input  logic              in_flush,
  input  logic              q_full,
  output logic              job_push,
  output utf8sd_pkg::job_t  job
);
  import utf8sd_pkg::*;

  logic [7:0]      pend_r [PEND_DEPTH];
  logic [2:0]      cnt_r, cnt_nxt;
  logic [2:0]      need_r, need_nxt;
  logic [2:0]      len_r, len_nxt;
  logic            inseq_r, inseq_nxt;
  logic [CP_W-1:0] acc_r, acc_nxt;
  logic            pend_we;
  logic            accept;
  logic [7:0]      b;
  logic [2:0]      blen;
  logic [CP_W-1:0] cp;
  logic            bad_cp;
  logic [5:0][7:0] dump_bytes;

  assign accept = in_push && !q_full;
  assign b      = in_data_byte;
  assign blen   = seq_length(b);
  assign cp     = {acc_r[CP_W-7:0], b[5:0]};
  assign bad_cp = (cp < min_value(len_r)) || ((cp >= CP_SURR_LO) && (cp <= CP_SURR_HI));

  // held bytes first, the current byte right after them
  always_comb begin
    for (int i = 0; i < MAX_BYTES - 1; i++) begin
      dump_bytes[i] = (3'(i) < cnt_r) ? pend_r[i] : b;
    end
    dump_bytes[MAX_BYTES-1] = b;
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    need_nxt  = need_r;
    len_nxt   = len_r;
    inseq_nxt = inseq_r;
    acc_nxt   = acc_r;
    pend_we   = 1'b0;
    job_push  = 1'b0;
    job.multi = 1'b0;
    job.kind  = KIND_UNKNOWN;
    job.value = {23'd0, b};
    job.bytes = dump_bytes;
    job.cnt   = cnt_r;
    if (accept) begin
      if (in_flush) begin
        job_push  = inseq_r;
        job.multi = 1'b1;
        cnt_nxt   = 3'd0;
        need_nxt  = 3'd0;
        inseq_nxt = 1'b0;
      end else if (!inseq_r) begin
        if (b < 8'h20 || b == 8'h7F) begin
          job_push = 1'b1;
          job.kind = KIND_CTRL;
        end else if (b < 8'h80) begin
          job_push = 1'b1;
          job.kind = KIND_CODE;
        end else if (blen == 3'd0) begin
          job_push = 1'b1;
        end else begin
          pend_we   = 1'b1;
          cnt_nxt   = 3'd1;
          need_nxt  = blen - 3'd1;
          len_nxt   = blen;
          inseq_nxt = 1'b1;
          acc_nxt   = {23'd0, b & lead_mask(blen)};
        end
      end else if (b[7:6] != 2'b10) begin
        job_push  = 1'b1;
        job.multi = 1'b1;
        job.cnt   = cnt_r + 3'd1;
        cnt_nxt   = 3'd0;
        need_nxt  = 3'd0;
        inseq_nxt = 1'b0;
      end else if (need_r > 3'd1) begin
        pend_we  = 1'b1;
        cnt_nxt  = cnt_r + 3'd1;
        need_nxt = need_r - 3'd1;
        acc_nxt  = cp;
      end else begin
        if (bad_cp) begin
          job_push  = 1'b1;
          job.multi = 1'b1;
          job.cnt   = cnt_r + 3'd1;
        end else if (cp != CP_BOM) begin
          job_push  = 1'b1;
          job.kind  = KIND_CODE;
          job.value = cp;
        end
        cnt_nxt   = 3'd0;
        need_nxt  = 3'd0;
        inseq_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 3'd0;
      need_r  <= 3'd0;
      inseq_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      need_r  <= need_nxt;
      inseq_r <= inseq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    acc_r <= acc_nxt;
    if (pend_we) begin
      pend_r[cnt_r] <= b;
    end
  end

  `U8SD_NEVER(a_idle_clear, !inseq_r && (cnt_r != 3'd0 || need_r != 3'd0), "idle with held bytes")
  `U8SD_ASSERT(a_seq_span, inseq_r |-> (({1'b0, cnt_r} + {1'b0, need_r}) == {1'b0, len_r}), "sequence length mismatch")
  `U8SD_ASSERT(a_flush_idle, (accept && in_flush) |=> !inseq_r, "flush left a sequence open")

endmodule

// File: hw/rtl/utf8sd_fifo.sv
// Two-entry job queue between front and back end.
module utf8sd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  utf8sd_pkg::job_t  wr_job,
  output logic              full,
  input  logic              rd_en,
  output logic              head_valid,
  output utf8sd_pkg::job_t  head_job
);
  import utf8sd_pkg::*;

  job_t       mem_r [Q_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_wr, do_rd;

  assign full       = (count_r == 2'(Q_DEPTH));
  assign head_valid = (count_r != 2'd0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_wr      = wr_en && !full;
  assign do_rd      = rd_en && head_valid;

  always_comb begin
    wr_ptr_nxt = do_wr ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

// File: hw/rtl/utf8sd_back.sv
// Back end: expands jobs into result words behind an output register.
module utf8sd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  utf8sd_pkg::job_t      head_job,
  output logic                  head_pop,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [1:0]            out_kind,
  output logic [30:0]           out_value,
  output logic                  out_last
);
  import utf8sd_pkg::*;

  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      kind_r, kind_nxt;
  logic [CP_W-1:0] value_r, value_nxt;
  logic            last_r, last_nxt;
  logic [2:0]      idx_r, idx_nxt;
  logic            load;
  logic            burst_end;

  assign load      = head_valid && (!out_valid_r || out_pop);
  assign burst_end = (idx_r == head_job.cnt - 3'd1);

  always_comb begin
    kind_nxt  = kind_r;
    value_nxt = value_r;
    last_nxt  = last_r;
    idx_nxt   = idx_r;
    head_pop  = 1'b0;
    if (load) begin
      if (!head_job.multi) begin
        kind_nxt  = head_job.kind;
        value_nxt = head_job.value;
        last_nxt  = 1'b1;
        head_pop  = 1'b1;
      end else begin
        kind_nxt  = KIND_UNKNOWN;
        value_nxt = {23'd0, head_job.bytes[idx_r]};
        last_nxt  = burst_end;
        head_pop  = burst_end;
        idx_nxt   = burst_end ? 3'd0 : idx_r + 3'd1;
      end
    end
    out_valid_nxt = load ? 1'b1 : (out_pop ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
    last_r  <= last_nxt;
  end

  assign out_empty = !out_valid_r;
  assign out_kind  = kind_r;
  assign out_value = value_r;
  assign out_last  = last_r;

endmodule

// File: verif/tb_utf8_stream_decoder.sv
// Self-checking testbench for utf8_stream_decoder: byte stream in, predicted decode words checked out.
module tb_utf8_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import utf8sd_pkg::*;

  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned RANDOM_BYTES = 500;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam logic [8:0]  FLUSH_WORD   = 9'h100;

  typedef struct packed {
    logic [1:0]  kind;
    logic [30:0] value;
    logic        last;
  } glyph_t;

  class decode_scoreboard;
    glyph_t      glyph_q[$];
    logic [7:0]  held[5];
    int unsigned held_cnt;
    int unsigned still_needed;
    bit          open;
    int unsigned errors;
    int unsigned n_code;
    int unsigned n_ctrl;
    int unsigned n_unknown;

    function new();
      held_cnt = 0;
      still_needed = 0;
      open = 0;
      errors = 0;
      n_code = 0;
      n_ctrl = 0;
      n_unknown = 0;
    endfunction

    function int unsigned pending();
      return glyph_q.size();
    endfunction

    function glyph_t mk(logic [1:0] kind, logic [30:0] value);
      glyph_t g;
      g.kind = kind;
      g.value = value;
      g.last = 1'b0;
      return g;
    endfunction

    // leading ones of a lead byte give the sequence length
    function int unsigned lead_len(logic [7:0] b);
      int unsigned n;
      n = 0;
      while (n < 8 && b[7-n]) n++;
      return (n >= 2 && n <= 6) ? n : 0;
    endfunction

    function logic [31:0] floor_for(int unsigned len);
      return (len == 2) ? 32'h80 : (32'h1 << (5 * len - 4));
    endfunction

    function void go_idle();
      held_cnt = 0;
      still_needed = 0;
      open = 0;
    endfunction

    function void note_word(logic [7:0] b, logic fl);
      glyph_t      burst[$];
      int unsigned len;
      logic [31:0] cp;
      if (fl) begin
        if (open) begin
          for (int i = 0; i < held_cnt; i++) burst.push_back(mk(KIND_UNKNOWN, {23'd0, held[i]}));
        end
        go_idle();
      end else if (!open) begin
        len = lead_len(b);
        if (b < 8'h20 || b == 8'h7F) begin
          burst.push_back(mk(KIND_CTRL, {23'd0, b}));
        end else if (b < 8'h80) begin
          burst.push_back(mk(KIND_CODE, {23'd0, b}));
        end else if (len == 0) begin
          burst.push_back(mk(KIND_UNKNOWN, {23'd0, b}));
        end else begin
          held[0] = b;
          held_cnt = 1;
          still_needed = len - 1;
          open = 1;
        end
      end else if (b[7:6] != 2'b10) begin
        // interrupted: held bytes and the interrupting byte all go out raw
        for (int i = 0; i < held_cnt; i++) burst.push_back(mk(KIND_UNKNOWN, {23'd0, held[i]}));
        burst.push_back(mk(KIND_UNKNOWN, {23'd0, b}));
        go_idle();
      end else if (still_needed > 1 && held_cnt < 5) begin
        held[held_cnt] = b;
        held_cnt++;
        still_needed--;
      end else begin
        len = held_cnt + 1;
        if (len > 6) len = 6;
        cp = {24'd0, held[0] & (8'hFF >> (len + 1))};
        for (int i = 1; i < held_cnt; i++) cp = (cp << 6) | {26'd0, held[i][5:0]};
        cp = ((cp << 6) | {26'd0, b[5:0]}) & 32'h7FFF_FFFF;
        if (cp < floor_for(len) || (cp >= 32'hD800 && cp <= 32'hDFFF)) begin
          for (int i = 0; i < held_cnt; i++) burst.push_back(mk(KIND_UNKNOWN, {23'd0, held[i]}));
          burst.push_back(mk(KIND_UNKNOWN, {23'd0, b}));
        end else if (cp != 32'hFEFF) begin
          burst.push_back(mk(KIND_CODE, cp[30:0]));
        end
        go_idle();
      end
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) glyph_q.push_back(burst[i]);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_word(logic [1:0] kind, logic [30:0] value, logic last);
      glyph_t want;
      if (glyph_q.size() == 0) begin
        report($sformatf("unexpected word kind=%0d value=%h last=%0d", kind, value, last));
      end else begin
        want = glyph_q.pop_front();
        if (kind !== want.kind)
          report($sformatf("kind %0d, expected %0d", kind, want.kind));
        if (value !== want.value)
          report($sformatf("value %h, expected %h", value, want.value));
        if (last !== want.last)
          report($sformatf("last %0d, expected %0d", last, want.last));
        case (want.kind)
          KIND_CODE: n_code++;
          KIND_CTRL: n_ctrl++;
          default:   n_unknown++;
        endcase
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_flush = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [1:0]  out_kind;
  logic [30:0] out_value;
  logic        out_last;

  decode_scoreboard sb = new();
  int unsigned      bytes_sent;
  int unsigned      flushes_sent;
  int unsigned      stall_left;
  int unsigned      quiet_cycles;
  bit               in_steady;
  bit               out_steady;

  utf8_stream_decoder dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_data_byte (in_data_byte),
    .in_flush     (in_flush),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_kind     (out_kind),
    .out_value    (out_value),
    .out_last     (out_last)
  );

  always #2 clk = ~clk;

  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(logic [7:0] b, logic fl);
    int unsigned gap;
    gap = pick_gap(in_steady);
    if (gap > 0) begin
      in_push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push = 1'b1;
    in_data_byte = b;
    in_flush = fl;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_word(b, fl);
    if (fl) flushes_sent++;
    else bytes_sent++;
    if ($urandom_range(0, 59) == 0) in_steady = !in_steady;
    @(negedge clk);
  endtask

  task automatic send_flush();
    send_word(8'($urandom), 1'b1);
  endtask

  task automatic send_cont(int unsigned n);
    repeat (n) send_word(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
  endtask

  task automatic send_directed();
    logic [8:0] seq[$];
    seq = '{9'h000, 9'h07F, 9'h020, 9'h080, 9'h0FE, 9'h0FF,
            9'h0C3, 9'h0A9,
            9'h0FD, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF,
            9'h0C1, 9'h0BF,
            9'h0ED, 9'h0A0, 9'h080,
            9'h0EF, 9'h0BB, 9'h0BF,
            9'h0F4, 9'h041,
            9'h0F8, 9'h088, FLUSH_WORD,
            FLUSH_WORD};
    foreach (seq[i]) send_word(seq[i][7:0], seq[i][8]);
  endtask

  task automatic send_random();
    int unsigned r;
    int unsigned len;
    int unsigned k;
    logic [7:0]  b;
    while (bytes_sent < RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        send_word(8'($urandom_range(0, 127)), 1'b0);
      end else if (r < 22) begin
        send_word(8'($urandom), 1'b0);
      end else if (r < 26) begin
        send_flush();
      end else if (r < 34) begin
        case ($urandom_range(0, 2))
          0: begin
            send_word(8'hED, 1'b0);
            send_word(8'hA0 | 8'($urandom_range(0, 31)), 1'b0);
            send_cont(1);
          end
          1: begin
            send_word(8'hEF, 1'b0);
            send_word(8'hBB, 1'b0);
            send_word(8'hBF, 1'b0);
          end
          default: begin
            // smallest lead of a length: overlong for length two, else unless the next payload is high enough
            len = $urandom_range(2, 6);
            send_word(~(8'hFF >> len), 1'b0);
            send_cont(len - 1);
          end
        endcase
      end else begin
        len = $urandom_range(2, 6);
        b = ~(8'hFF >> len) | (8'($urandom) & (8'hFF >> (len + 1)));
        send_word(b, 1'b0);
        if ($urandom_range(0, 99) < 15) begin
          k = $urandom_range(0, len - 2);
          send_cont(k);
          if ($urandom_range(0, 2) == 0) begin
            send_flush();
          end else begin
            do b = 8'($urandom); while (b[7:6] == 2'b10);
            send_word(b, 1'b0);
          end
        end else begin
          send_cont(len - 1);
        end
      end
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop = 1'b0;
    end else if (stall_left > 0) begin
      out_pop = 1'b0;
      stall_left--;
    end else begin
      out_pop = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      sb.check_word(out_kind, out_value, out_last);
      stall_left = pick_gap(out_steady);
      if ($urandom_range(0, 79) == 0) out_steady = !out_steady;
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no word moved for %0d cycles, %0d still expected",
                 STALL_LIMIT, sb.pending());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    bytes_sent = 0;
    flushes_sent = 0;
    stall_left = 0;
    quiet_cycles = 0;
    in_steady = 1'b0;
    out_steady = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    send_directed();
    send_random();
    send_flush();
    in_push = 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d bytes and %0d flushes; checked %0d code points, %0d control, %0d unknown",
             bytes_sent, flushes_sent, sb.n_code, sb.n_ctrl, sb.n_unknown);
    $display("Mismatches: %0d", sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
